// ===== hdl/rscb_pkg.sv =====
// Shared types and constants for the rectangle shape coverage and blend block.
// No dependencies; every other file of the block imports this package.
package rscb_pkg;

    // Field widths fixed by the pixel and register formats
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int OUT_DATA_W = NUM_CHAN * CHAN_W;
    localparam int SPAN_W     = 15;
    localparam int RAD_W      = 16;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    // Smallest geometry width that holds a span grown by half a stroke on each side
    localparam int GEO_MIN_W  = 17;

    // Blend constants
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
    localparam logic [CHAN_W-1:0] BLEND_BIAS = 8'd127;

    // Cycles the derived geometry needs after reset or a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECT_LEFT     = 4'd0,
        REG_RECT_TOP      = 4'd1,
        REG_RECT_SPAN_X   = 4'd2,
        REG_RECT_SPAN_Y   = 4'd3,
        REG_CORNER_RADIUS = 4'd4,
        REG_STROKE_WIDTH  = 4'd5,
        REG_FILL_COLOR    = 4'd6,
        REG_SHAPE_MODE    = 4'd7
    } t_cfg_reg;

    // Shape modes
    typedef enum logic [1:0] {
        MODE_FILL_RECT    = 2'd0,
        MODE_STROKE_RECT  = 2'd1,
        MODE_FILL_ROUND   = 2'd2,
        MODE_STROKE_ROUND = 2'd3
    } t_shape_mode;

    // Per-stage advance enables of the pixel pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // Status of the derived geometry
    typedef struct packed {
        logic busy;      // geometry still settling
        logic draw_en;   // alpha nonzero and stroke width usable
        logic inner_en;  // a nonempty inner shape is cut out
    } t_geo_stat;

    // Width of the signed geometry arithmetic for a given coordinate width
    function automatic int f_geo_w(input int coord_bits);
        return ((coord_bits > GEO_MIN_W) ? coord_bits : GEO_MIN_W) + 2;
    endfunction

endpackage

// ===== hdl/rscb_cfg.sv =====
// Configuration registers and the three-stage setup pipeline that derives the
// outer and inner box edges, core bounds and squared radii. Uses rscb_pkg.
module rscb_cfg #(
    parameter int COORD_BITS = 16,
    localparam int GEO_W = rscb_pkg::f_geo_w(COORD_BITS)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_wr,
    input  logic [rscb_pkg::CFG_IDX_W-1:0]        i_wr_index,
    input  logic [rscb_pkg::CFG_DATA_W-1:0]       i_wr_data,
    // outer box
    output logic signed [GEO_W-1:0]               o_ox0,
    output logic signed [GEO_W-1:0]               o_ox1,
    output logic signed [GEO_W-1:0]               o_oy0,
    output logic signed [GEO_W-1:0]               o_oy1,
    output logic signed [GEO_W-1:0]               o_ocx0,
    output logic signed [GEO_W-1:0]               o_ocx1,
    output logic signed [GEO_W-1:0]               o_ocy0,
    output logic signed [GEO_W-1:0]               o_ocy1,
    output logic [rscb_pkg::SQ_W-1:0]             o_orad2,
    // inner box
    output logic signed [GEO_W-1:0]               o_ix0,
    output logic signed [GEO_W-1:0]               o_ix1,
    output logic signed [GEO_W-1:0]               o_iy0,
    output logic signed [GEO_W-1:0]               o_iy1,
    output logic signed [GEO_W-1:0]               o_icx0,
    output logic signed [GEO_W-1:0]               o_icx1,
    output logic signed [GEO_W-1:0]               o_icy0,
    output logic signed [GEO_W-1:0]               o_icy1,
    output logic [rscb_pkg::SQ_W-1:0]             o_irad2,
    output logic [rscb_pkg::COLOR_W-1:0]          o_color,
    output rscb_pkg::t_geo_stat                   o_stat
);
    import rscb_pkg::*;

    // Register file
    logic signed [COORD_BITS-1:0] r_rect_left;
    logic signed [COORD_BITS-1:0] r_rect_top;
    logic [SPAN_W-1:0]            r_span_x;
    logic [SPAN_W-1:0]            r_span_y;
    logic [RAD_W-1:0]             r_radius;
    logic [RAD_W-1:0]             r_stroke;
    logic [COLOR_W-1:0]           r_color;
    t_shape_mode                  r_mode;
    logic [1:0]                   r_settle;

    // Setup stage 1
    logic signed [GEO_W-1:0] w_x, w_y, w_w, w_h, w_g, w_i;
    logic [RAD_W-1:0]        w_inset;
    logic                    w_stroke_mode;
    logic [RAD_W:0]          n_oreq;
    logic [RAD_W-1:0]        n_ireq;
    logic signed [GEO_W-1:0] r1_ox0, r1_ox1, r1_oy0, r1_oy1;
    logic signed [GEO_W-1:0] r1_ix0, r1_ix1, r1_iy0, r1_iy1;
    logic signed [GEO_W-1:0] r1_ow, r1_oh, r1_iw, r1_ih;
    logic [RAD_W:0]          r1_oreq;
    logic [RAD_W-1:0]        r1_ireq;
    logic                    r1_apply;
    logic                    r1_enable;

    // Setup stage 2
    logic signed [GEO_W-1:0] w_omin, w_imin;
    logic [RAD_W-1:0]        w_ohalf;
    logic [RAD_W-2:0]        w_ihalf;
    logic [RAD_W-1:0]        n_orad, n_irad;
    logic                    n_ivalid;
    logic [RAD_W-1:0]        r2_orad, r2_irad;
    logic                    r2_ivalid;
    logic                    r2_enable;

    // Setup stage 3
    logic signed [GEO_W-1:0] r3_ocx0, r3_ocx1, r3_ocy0, r3_ocy1;
    logic signed [GEO_W-1:0] r3_icx0, r3_icx1, r3_icy0, r3_icy1;
    logic [SQ_W-1:0]         r3_orad2, r3_irad2;

    // Take register writes and restart the settle count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left <= '0;
            r_rect_top  <= '0;
            r_span_x    <= '0;
            r_span_y    <= '0;
            r_radius    <= '0;
            r_stroke    <= RAD_W'(1);
            r_color     <= '0;
            r_mode      <= MODE_FILL_RECT;
            r_settle    <= SETTLE_CYCLES;
        end else begin
            if (i_wr) begin
                r_settle <= SETTLE_CYCLES;
                case (i_wr_index)
                    REG_RECT_LEFT:     r_rect_left <= $signed(i_wr_data[COORD_BITS-1:0]);
                    REG_RECT_TOP:      r_rect_top  <= $signed(i_wr_data[COORD_BITS-1:0]);
                    REG_RECT_SPAN_X:   r_span_x    <= i_wr_data[SPAN_W-1:0];
                    REG_RECT_SPAN_Y:   r_span_y    <= i_wr_data[SPAN_W-1:0];
                    REG_CORNER_RADIUS: r_radius    <= i_wr_data[RAD_W-1:0];
                    REG_STROKE_WIDTH:  r_stroke    <= i_wr_data[RAD_W-1:0];
                    REG_FILL_COLOR:    r_color     <= i_wr_data[COLOR_W-1:0];
                    REG_SHAPE_MODE:    r_mode      <= t_shape_mode'(i_wr_data[1:0]);
                    default: ;
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // Stage 1: outer edges grown by half the stroke in stroke modes, inner edges shrunk by the rest
    always_comb begin
        w_stroke_mode = (r_mode == MODE_STROKE_RECT) || (r_mode == MODE_STROKE_ROUND);
        w_inset = r_stroke - RAD_W'(r_stroke[RAD_W-1:1]);
        w_x = GEO_W'(r_rect_left);
        w_y = GEO_W'(r_rect_top);
        w_w = $signed(GEO_W'(r_span_x));
        w_h = $signed(GEO_W'(r_span_y));
        w_g = w_stroke_mode ? $signed(GEO_W'(r_stroke[RAD_W-1:1])) : '0;
        w_i = $signed(GEO_W'(w_inset));
        case (r_mode)
            MODE_FILL_ROUND:   n_oreq = (RAD_W+1)'(r_radius);
            MODE_STROKE_ROUND: n_oreq = (RAD_W+1)'(r_radius) + (RAD_W+1)'(r_stroke[RAD_W-1:1]);
            default:           n_oreq = '0;
        endcase
        if ((r_mode == MODE_STROKE_ROUND) && (r_radius > w_inset)) begin
            n_ireq = r_radius - w_inset;
        end else begin
            n_ireq = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ox0    <= w_x - w_g;
        r1_ox1    <= w_x + w_w + w_g;
        r1_oy0    <= w_y - w_g;
        r1_oy1    <= w_y + w_h + w_g;
        r1_ix0    <= w_x + w_i;
        r1_ix1    <= w_x + w_w - w_i;
        r1_iy0    <= w_y + w_i;
        r1_iy1    <= w_y + w_h - w_i;
        r1_ow     <= w_w + w_g + w_g;
        r1_oh     <= w_h + w_g + w_g;
        r1_iw     <= w_w - w_i - w_i;
        r1_ih     <= w_h - w_i - w_i;
        r1_oreq   <= n_oreq;
        r1_ireq   <= n_ireq;
        r1_apply  <= w_stroke_mode;
        r1_enable <= (r_color[CHAN_W-1:0] != '0) && !(w_stroke_mode && (r_stroke == '0));
    end

    // Stage 2: clamp each radius to half the shorter side of its box
    always_comb begin
        w_omin   = (r1_ow < r1_oh) ? r1_ow : r1_oh;
        w_imin   = (r1_iw < r1_ih) ? r1_iw : r1_ih;
        w_ohalf  = w_omin[RAD_W:1];
        w_ihalf  = w_imin[RAD_W-1:1];
        n_orad   = (r1_oreq < {1'b0, w_ohalf}) ? r1_oreq[RAD_W-1:0] : w_ohalf;
        n_irad   = (r1_ireq < {1'b0, w_ihalf}) ? r1_ireq : {1'b0, w_ihalf};
        n_ivalid = r1_apply && (r1_iw > 0) && (r1_ih > 0);
    end

    always_ff @(posedge i_clk) begin
        r2_orad   <= n_orad;
        r2_irad   <= n_irad;
        r2_ivalid <= n_ivalid;
        r2_enable <= r1_enable;
    end

    // Stage 3: straight-edge core bounds and squared radii
    always_ff @(posedge i_clk) begin
        r3_ocx0  <= r1_ox0 + $signed(GEO_W'(r2_orad));
        r3_ocx1  <= r1_ox1 - $signed(GEO_W'(r2_orad));
        r3_ocy0  <= r1_oy0 + $signed(GEO_W'(r2_orad));
        r3_ocy1  <= r1_oy1 - $signed(GEO_W'(r2_orad));
        r3_icx0  <= r1_ix0 + $signed(GEO_W'(r2_irad));
        r3_icx1  <= r1_ix1 - $signed(GEO_W'(r2_irad));
        r3_icy0  <= r1_iy0 + $signed(GEO_W'(r2_irad));
        r3_icy1  <= r1_iy1 - $signed(GEO_W'(r2_irad));
        r3_orad2 <= r2_orad * r2_orad;
        r3_irad2 <= r2_irad * r2_irad;
    end

    // Drive geometry
    assign o_ox0  = r1_ox0;
    assign o_ox1  = r1_ox1;
    assign o_oy0  = r1_oy0;
    assign o_oy1  = r1_oy1;
    assign o_ocx0 = r3_ocx0;
    assign o_ocx1 = r3_ocx1;
    assign o_ocy0 = r3_ocy0;
    assign o_ocy1 = r3_ocy1;
    assign o_orad2 = r3_orad2;
    assign o_ix0  = r1_ix0;
    assign o_ix1  = r1_ix1;
    assign o_iy0  = r1_iy0;
    assign o_iy1  = r1_iy1;
    assign o_icx0 = r3_icx0;
    assign o_icx1 = r3_icx1;
    assign o_icy0 = r3_icy0;
    assign o_icy1 = r3_icy1;
    assign o_irad2 = r3_irad2;
    assign o_color = r_color;
    assign o_stat.busy     = (r_settle != '0);
    assign o_stat.draw_en  = r2_enable;
    assign o_stat.inner_en = r2_ivalid;

endmodule

// ===== hdl/rscb_box_test.sv =====
// Three-stage hit test of one pixel against one rounded box: edge compares,
// corner offset squares, distance compare. Uses rscb_pkg.
module rscb_box_test #(
    parameter int COORD_BITS = 16,
    localparam int GEO_W = rscb_pkg::f_geo_w(COORD_BITS)
) (
    input  logic                            i_clk,
    input  rscb_pkg::t_pipe_en              i_en,
    input  logic signed [COORD_BITS-1:0]    i_px,
    input  logic signed [COORD_BITS-1:0]    i_py,
    input  logic signed [GEO_W-1:0]         i_x0,
    input  logic signed [GEO_W-1:0]         i_x1,
    input  logic signed [GEO_W-1:0]         i_y0,
    input  logic signed [GEO_W-1:0]         i_y1,
    input  logic signed [GEO_W-1:0]         i_cx0,
    input  logic signed [GEO_W-1:0]         i_cx1,
    input  logic signed [GEO_W-1:0]         i_cy0,
    input  logic signed [GEO_W-1:0]         i_cy1,
    input  logic [rscb_pkg::SQ_W-1:0]       i_rad2,
    output logic                            o_hit
);
    import rscb_pkg::*;

    logic signed [GEO_W-1:0] w_px, w_py;
    logic signed [GEO_W-1:0] w_dxl, w_dxr, w_dyt, w_dyb;
    logic [RAD_W-1:0]        w_dx, w_dy;
    logic [SQ_W:0]           w_dist2;

    logic                    r1_in, r1_core, r1_left, r1_top;
    logic [RAD_W-1:0]        r1_dxl, r1_dxr, r1_dyt, r1_dyb;
    logic                    r2_in, r2_core;
    logic [SQ_W-1:0]         r2_dx2, r2_dy2;
    logic                    r3_hit;

    // Stage 1: edge compares and offsets to both corner centers
    always_comb begin
        w_px  = GEO_W'(i_px);
        w_py  = GEO_W'(i_py);
        // center on the low side sits one pixel below the core bound
        w_dxl = i_cx0 + ~w_px;
        w_dxr = w_px - i_cx1;
        w_dyt = i_cy0 + ~w_py;
        w_dyb = w_py - i_cy1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_in   <= (w_px >= i_x0) && (w_px < i_x1) && (w_py >= i_y0) && (w_py < i_y1);
            r1_core <= ((w_px >= i_cx0) && (w_px < i_cx1)) ||
                       ((w_py >= i_cy0) && (w_py < i_cy1));
            r1_left <= (w_px < i_cx0);
            r1_top  <= (w_py < i_cy0);
            r1_dxl  <= w_dxl[RAD_W-1:0];
            r1_dxr  <= w_dxr[RAD_W-1:0];
            r1_dyt  <= w_dyt[RAD_W-1:0];
            r1_dyb  <= w_dyb[RAD_W-1:0];
        end
    end

    // Stage 2: square the offsets of the nearest corner
    assign w_dx = r1_left ? r1_dxl : r1_dxr;
    assign w_dy = r1_top  ? r1_dyt : r1_dyb;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_in   <= r1_in;
            r2_core <= r1_core;
            r2_dx2  <= w_dx * w_dx;
            r2_dy2  <= w_dy * w_dy;
        end
    end

    // Stage 3: inside the box and either on the core cross or within the arc
    assign w_dist2 = (SQ_W+1)'(r2_dx2) + (SQ_W+1)'(r2_dy2);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_hit <= r2_in && (r2_core || (w_dist2 <= (SQ_W+1)'(i_rad2)));
        end
    end

    assign o_hit = r3_hit;

endmodule

// ===== hdl/rscb_blend.sv =====
// Three-stage alpha blend of the fill color over the destination RGB with
// rounding, division by 255 done by reciprocal shift. Uses rscb_pkg.
module rscb_blend (
    input  logic                                                i_clk,
    input  rscb_pkg::t_pipe_en                                  i_en,
    input  logic [rscb_pkg::COLOR_W-1:0]                        i_color,
    input  logic [rscb_pkg::NUM_CHAN-1:0][rscb_pkg::CHAN_W-1:0] i_dst,
    output logic [rscb_pkg::NUM_CHAN-1:0][rscb_pkg::CHAN_W-1:0] o_mix,
    output logic [rscb_pkg::NUM_CHAN-1:0][rscb_pkg::CHAN_W-1:0] o_dst
);
    import rscb_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;

    logic [NUM_CHAN-1:0][CHAN_W-1:0] w_src;
    logic [CHAN_W-1:0]               w_alpha;
    logic [CHAN_W-1:0]               w_inv_alpha;
    logic [NUM_CHAN-1:0][PROD_W-1:0] w_quot;

    logic [NUM_CHAN-1:0][PROD_W-1:0] r1_sa, r1_da;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] r1_dst;
    logic [NUM_CHAN-1:0][PROD_W-1:0] r2_sum;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] r2_dst;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] r3_mix;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] r3_dst;

    // Unpack color: red in the top byte, alpha in the bottom byte
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_src[c] = i_color[COLOR_W-1-CHAN_W*c -: CHAN_W];
        end
        w_alpha     = i_color[CHAN_W-1:0];
        w_inv_alpha = CHAN_MAX - w_alpha;
    end

    // Stage 1: weight source and destination
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r1_sa[c] <= w_src[c] * w_alpha;
                r1_da[c] <= i_dst[c] * w_inv_alpha;
            end
            r1_dst <= i_dst;
        end
    end

    // Stage 2: sum with rounding bias; stays below 2^16
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r2_sum[c] <= PROD_W'((PROD_W+1)'(r1_sa[c]) + (PROD_W+1)'(r1_da[c]) +
                                     (PROD_W+1)'(BLEND_BIAS));
            end
            r2_dst <= r1_dst;
        end
    end

    // Stage 3: divide by 255 as (x + x/256 + 1) / 256, exact over the sum range
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_quot[c] = r2_sum[c] + PROD_W'(r2_sum[c][PROD_W-1:CHAN_W]) + PROD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r3_mix[c] <= w_quot[c][PROD_W-1:CHAN_W];
            end
            r3_dst <= r2_dst;
        end
    end

    assign o_mix = r3_mix;
    assign o_dst = r3_dst;

endmodule

// ===== hdl/rect_shape_coverage_blend.sv =====
// Top level of the rectangle shape coverage and blend shader.
// Instantiates rscb_cfg, two rscb_box_test and rscb_blend; uses rscb_pkg.
//
// One pixel per clock while nothing stalls: a new pixel transaction can be taken
// in every cycle in which o_s_axis_tready is high. Each pixel passes four register
// stages (edge compares with the color weights, corner squares with the blend
// sum, distance compare with the divide by 255, select into the output
// register), and its result waits in the output register until it is taken. No
// product is wider than 16 by 16 bits, and each stage holds only one level of
// products, so without stalls the stream rate is set by the clock alone. Stages
// advance independently, so bubbles close up behind a stalled output. After
// reset and after every register write o_s_axis_tready stays low while the
// derived geometry settles. o_s_axis_tready is also low in any cycle in which
// i_cfg_valid is high. Register writes are always taken and belong between
// frames, with no pixel in flight. A covered pixel with nonzero alpha gets the
// blended color and tuser set; any other pixel passes its destination RGB
// through with tuser clear.
module rect_shape_coverage_blend #(
    parameter int COORD_BITS = 16,
    localparam int IN_W = ((2 * COORD_BITS + rscb_pkg::OUT_DATA_W + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rscb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rscb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel input
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // fields from bit 0: pixel_x, pixel_y, dst_red, dst_green, dst_blue, zero pad
    input  logic [IN_W-1:0]                     i_s_axis_tdata,
    // pixel result
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // fields from bit 0: out_red, out_green, out_blue
    output logic [rscb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // fields from bit 0: covered
    output logic                                o_m_axis_tuser
);
    import rscb_pkg::*;

    localparam int GEO_W = f_geo_w(COORD_BITS);

    // Geometry from the setup pipeline
    logic signed [GEO_W-1:0] w_ox0, w_ox1, w_oy0, w_oy1, w_ocx0, w_ocx1, w_ocy0, w_ocy1;
    logic signed [GEO_W-1:0] w_ix0, w_ix1, w_iy0, w_iy1, w_icx0, w_icx1, w_icy0, w_icy1;
    logic [SQ_W-1:0]         w_orad2, w_irad2;
    logic [COLOR_W-1:0]      w_color;
    t_geo_stat               w_stat;

    // Pixel pipeline control and data
    t_pipe_en                        w_en;
    logic                            w_in_acc;
    logic [4:1]                      r_v;
    logic signed [COORD_BITS-1:0]    w_px, w_py;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] w_dst, w_mix, w_dst_d;
    logic                            w_ohit, w_ihit;
    logic                            n_cover;
    logic [OUT_DATA_W-1:0]           r_out_rgb;
    logic                            r_out_cov;

    assign o_cfg_ready = 1'b1;

    rscb_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_ox0      (w_ox0),
        .o_ox1      (w_ox1),
        .o_oy0      (w_oy0),
        .o_oy1      (w_oy1),
        .o_ocx0     (w_ocx0),
        .o_ocx1     (w_ocx1),
        .o_ocy0     (w_ocy0),
        .o_ocy1     (w_ocy1),
        .o_orad2    (w_orad2),
        .o_ix0      (w_ix0),
        .o_ix1      (w_ix1),
        .o_iy0      (w_iy0),
        .o_iy1      (w_iy1),
        .o_icx0     (w_icx0),
        .o_icx1     (w_icx1),
        .o_icy0     (w_icy0),
        .o_icy1     (w_icy1),
        .o_irad2    (w_irad2),
        .o_color    (w_color),
        .o_stat     (w_stat)
    );

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        w_en.s4 = !r_v[4] || i_m_axis_tready;
        w_en.s3 = !r_v[3] || w_en.s4;
        w_en.s2 = !r_v[2] || w_en.s3;
        w_en.s1 = !r_v[1] || w_en.s2;
    end

    assign o_s_axis_tready = w_en.s1 && !w_stat.busy && !i_cfg_valid;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en.s1) r_v[1] <= w_in_acc;
            if (w_en.s2) r_v[2] <= r_v[1];
            if (w_en.s3) r_v[3] <= r_v[2];
            if (w_en.s4) r_v[4] <= r_v[3];
        end
    end

    // Unpack the pixel transaction
    always_comb begin
        w_px = $signed(i_s_axis_tdata[COORD_BITS-1:0]);
        w_py = $signed(i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_dst[c] = i_s_axis_tdata[2*COORD_BITS + CHAN_W*c +: CHAN_W];
        end
    end

    rscb_box_test #(
        .COORD_BITS (COORD_BITS)
    ) u_outer (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_px   (w_px),
        .i_py   (w_py),
        .i_x0   (w_ox0),
        .i_x1   (w_ox1),
        .i_y0   (w_oy0),
        .i_y1   (w_oy1),
        .i_cx0  (w_ocx0),
        .i_cx1  (w_ocx1),
        .i_cy0  (w_ocy0),
        .i_cy1  (w_ocy1),
        .i_rad2 (w_orad2),
        .o_hit  (w_ohit)
    );

    rscb_box_test #(
        .COORD_BITS (COORD_BITS)
    ) u_inner (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_px   (w_px),
        .i_py   (w_py),
        .i_x0   (w_ix0),
        .i_x1   (w_ix1),
        .i_y0   (w_iy0),
        .i_y1   (w_iy1),
        .i_cx0  (w_icx0),
        .i_cx1  (w_icx1),
        .i_cy0  (w_icy0),
        .i_cy1  (w_icy1),
        .i_rad2 (w_irad2),
        .o_hit  (w_ihit)
    );

    rscb_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_color (w_color),
        .i_dst   (w_dst),
        .o_mix   (w_mix),
        .o_dst   (w_dst_d)
    );

    // Stage 4: drawing enabled, in the outer shape and not cut out by the inner one
    assign n_cover = w_stat.draw_en && w_ohit && !(w_stat.inner_en && w_ihit);

    always_ff @(posedge i_clk) begin
        if (w_en.s4) begin
            r_out_cov <= n_cover;
            r_out_rgb <= n_cover ? w_mix : w_dst_d;
        end
    end

    assign o_m_axis_tvalid = r_v[4];
    assign o_m_axis_tdata  = r_out_rgb;
    assign o_m_axis_tuser  = r_out_cov;

    // A register write blocks pixels while the geometry settles
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> !o_s_axis_tready)
        else $error("pixel accepted right after a register write");

    // An accepted pixel occupies stage 1 next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_v[1])
        else $error("accepted pixel did not enter stage 1");

    // A stalled stage 1 keeps its pixel
    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !w_en.s1) |=> r_v[1])
        else $error("stage 1 pixel lost under stall");

    // Reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && (r_v == '0)))
        else $error("pipeline not empty after reset");

endmodule
